// ===== sv/bitplane_xor_row_defilter_assert.svh =====
// Assertion macros shared by the defilter RTL.
`ifndef BITPLANE_XOR_ROW_DEFILTER_ASSERT_SVH
`define BITPLANE_XOR_ROW_DEFILTER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BXD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define BXD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/bxd_pkg.sv =====
// Package: sizes, codes, types and helper functions of the bitplane defilter.
package bxd_pkg;

    localparam int MAX_BYTE_WIDTH = 64;
    localparam int MAX_ROWS       = 256;
    localparam int MAX_PLANES     = 9;

    localparam int BYTE_W = 8;
    localparam int MODE_W = 4;
    localparam int PL_W   = 4;
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int COL_W  = $clog2(MAX_BYTE_WIDTH);

    // Row and plane strides are powers of two, so the address is a concatenation.
    localparam int ADDR_W     = PL_W + ROW_W + COL_W;
    localparam int STORE_SIZE = MAX_PLANES * MAX_ROWS * MAX_BYTE_WIDTH;

    localparam int BW_W  = 7;
    localparam int TH_W  = 9;
    localparam int NR_W  = 9;
    localparam int NP_W  = 4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BYTE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_COUNT = 3'd3;

    // Filter selects (low three bits of the mode)
    localparam logic [2:0] SEL_NONE   = 3'd0;
    localparam logic [2:0] SEL_PREFIX = 3'd1;
    localparam logic [2:0] SEL_ROW    = 3'd2;
    localparam logic [2:0] SEL_TILE   = 3'd3;
    localparam logic [2:0] SEL_PLANE1 = 3'd4;
    localparam logic [2:0] SEL_PLANE4 = 3'd7;

    localparam int MODE_INV_BIT = 3;

    typedef struct packed {
        logic [BW_W-1:0] byte_width;
        logic [TH_W-1:0] tile_height;
        logic [NR_W-1:0] image_rows;
        logic [NP_W-1:0] plane_count;
    } t_cfg;

    typedef struct packed {
        logic [PL_W-1:0]  plane;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last_row;
        logic             last_img;
    } t_pos;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic              zero;
    } t_ref;

    function automatic logic [ADDR_W-1:0] store_addr(
        input logic [PL_W-1:0]  pl,
        input logic [ROW_W-1:0] row,
        input logic [COL_W-1:0] col
    );
        return {pl, row, col};
    endfunction

    // Undo an MSB-first running XOR: bit i is the XOR of bits 7 down to i.
    function automatic logic [BYTE_W-1:0] prefix_xor(input logic [BYTE_W-1:0] x);
        logic [BYTE_W-1:0] r;
        r = x;
        r = r ^ (r >> 1);
        r = r ^ (r >> 2);
        r = r ^ (r >> 4);
        return r;
    endfunction

endpackage

// ===== sv/bxd_in_if.sv =====
// Input channel: filtered byte and row filter mode.
interface bxd_in_if;
    logic                      valid;
    logic                      ready;
    logic [bxd_pkg::BYTE_W-1:0] filtered_byte;
    logic [bxd_pkg::MODE_W-1:0] filter_mode;

    modport source (output valid, output filtered_byte, output filter_mode, input ready);
    modport sink   (input valid, input filtered_byte, input filter_mode, output ready);
endinterface

// ===== sv/bxd_out_if.sv =====
// Output channel: defiltered byte and its position.
interface bxd_out_if;
    logic                       valid;
    logic                       ready;
    logic [bxd_pkg::BYTE_W-1:0] pixel_byte;
    logic [bxd_pkg::PL_W-1:0]   plane_index;
    logic [bxd_pkg::ROW_W-1:0]  row_index;
    logic [bxd_pkg::COL_W-1:0]  column_index;
    logic                       last_of_row;
    logic                       last_of_image;

    modport source (output valid, output pixel_byte, output plane_index, output row_index,
                    output column_index, output last_of_row, output last_of_image,
                    input ready);
    modport sink   (input valid, input pixel_byte, input plane_index, input row_index,
                    input column_index, input last_of_row, input last_of_image,
                    output ready);
endinterface

// ===== sv/bxd_cfg_if.sv =====
// Configuration write channel: register index and data.
interface bxd_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [bxd_pkg::CFG_IDX_W-1:0]  index;
    logic [bxd_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/bxd_store.sv =====
// Image store: one write port, one registered read port.
module bxd_store (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [bxd_pkg::ADDR_W-1:0] i_waddr,
    input  logic [bxd_pkg::BYTE_W-1:0] i_wdata,
    input  logic                       i_re,
    input  logic [bxd_pkg::ADDR_W-1:0] i_raddr,
    output logic [bxd_pkg::BYTE_W-1:0] o_rdata
);
    logic [bxd_pkg::BYTE_W-1:0] r_mem [bxd_pkg::STORE_SIZE];
    logic [bxd_pkg::BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read returns old data on a same-address write; caller forwards
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sv/bxd_pos.sv =====
// Position counters and reference address generation.
module bxd_pos (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  bxd_pkg::t_cfg              i_cfg,
    input  logic                       i_adv,
    input  logic [bxd_pkg::MODE_W-1:0] i_mode,
    output bxd_pkg::t_pos              o_pos,
    output logic [bxd_pkg::ADDR_W-1:0] o_addr,
    output bxd_pkg::t_ref              o_ref
);
    logic [bxd_pkg::COL_W-1:0] r_col, n_col;
    logic [bxd_pkg::ROW_W-1:0] r_row, n_row;
    logic [bxd_pkg::PL_W-1:0]  r_pl, n_pl;
    logic                      lcol, lrow, lpl;
    logic [2:0]                sel;
    logic [bxd_pkg::PL_W-1:0]  pl_back;

    assign lcol = ({1'b0, r_col} + 7'd1) >= i_cfg.byte_width;
    assign lrow = ({1'b0, r_row} + 9'd1) >= i_cfg.image_rows;
    assign lpl  = ({1'b0, r_pl} + 5'd1) >= {1'b0, i_cfg.plane_count};

    assign o_pos.plane    = r_pl;
    assign o_pos.row      = r_row;
    assign o_pos.col      = r_col;
    assign o_pos.last_row = lcol;
    assign o_pos.last_img = lcol && lrow && lpl;
    assign o_addr = bxd_pkg::store_addr(r_pl, r_row, r_col);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        n_pl  = r_pl;
        if (!lcol) begin
            n_col = r_col + 6'd1;
        end else begin
            n_col = '0;
            if (!lrow) begin
                n_row = r_row + 8'd1;
            end else begin
                n_row = '0;
                n_pl  = lpl ? '0 : r_pl + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_pl  <= '0;
        end else if (i_adv) begin
            r_col <= n_col;
            r_row <= n_row;
            r_pl  <= n_pl;
        end
    end

    // Reference position; off-image references read as zero.
    assign sel     = i_mode[2:0];
    assign pl_back = {1'b0, sel} - 4'd3;

    always_comb begin
        o_ref.addr = o_addr;
        o_ref.zero = 1'b1;
        case (sel) inside
            bxd_pkg::SEL_ROW: begin
                o_ref.zero = (r_row == '0);
                o_ref.addr = bxd_pkg::store_addr(r_pl, r_row - 8'd1, r_col);
            end
            bxd_pkg::SEL_TILE: begin
                o_ref.zero = ({1'b0, r_row} < i_cfg.tile_height);
                o_ref.addr = bxd_pkg::store_addr(r_pl, r_row - i_cfg.tile_height[7:0], r_col);
            end
            [bxd_pkg::SEL_PLANE1:bxd_pkg::SEL_PLANE4]: begin
                o_ref.zero = (r_pl < pl_back);
                o_ref.addr = bxd_pkg::store_addr(r_pl - pl_back, r_row, r_col);
            end
            default: begin
                o_ref.zero = 1'b1;
            end
        endcase
    end
endmodule

// ===== sv/bitplane_xor_row_defilter.sv =====
// Top level of the bitplane XOR row defilter.
//
// Channels: i_in takes one filtered byte with its row filter mode per item;
// o_out gives one defiltered byte per input item, with plane, row and column
// and the end-of-row / end-of-image flags. i_cfg writes byte_width (0),
// tile_height (1), image_rows (2) and plane_count (3); it is always ready.
// The user must write i_cfg only while the block is idle, which the block
// does not enforce. A result passes the compute stage and then the output
// register before it is valid on o_out. Throughput: one item per cycle while
// o_out accepts results, set by the image store's single read and single write
// port, one of each per item. The reference read is issued at accept; the
// store is written when the item moves into the output register, and a
// write to the entry just being read is forwarded.
// Reset: position counters and the row carry clear, registers return to 1,
// both pipeline stages empty. The store is not cleared; every reference of a
// well-formed stream lies at an already written position.
// Stall: while o_out is not taken the output register holds, the compute
// stage holds one more item and i_in stays ready only until that stage fills.
module bitplane_xor_row_defilter (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bxd_in_if.sink     i_in,
    bxd_cfg_if.sink    i_cfg,
    bxd_out_if.source  o_out
);
    `include "bitplane_xor_row_defilter_assert.svh"

    // ---------------- configuration registers ----------------
    logic [bxd_pkg::BW_W-1:0] r_bw;
    logic [bxd_pkg::TH_W-1:0] r_th;
    logic [bxd_pkg::NR_W-1:0] r_nr;
    logic [bxd_pkg::NP_W-1:0] r_np;
    bxd_pkg::t_cfg            cfg;
    logic                     cfg_we;

    assign i_cfg.ready = 1'b1;
    assign cfg_we = i_cfg.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bw <= 7'd1;
            r_th <= 9'd1;
            r_nr <= 9'd1;
            r_np <= 4'd1;
        end else if (cfg_we) begin
            case (i_cfg.index)
                bxd_pkg::CFG_BYTE_WIDTH:  r_bw <= i_cfg.data[bxd_pkg::BW_W-1:0];
                bxd_pkg::CFG_TILE_HEIGHT: r_th <= i_cfg.data[bxd_pkg::TH_W-1:0];
                bxd_pkg::CFG_IMAGE_ROWS:  r_nr <= i_cfg.data[bxd_pkg::NR_W-1:0];
                bxd_pkg::CFG_PLANE_COUNT: r_np <= i_cfg.data[bxd_pkg::NP_W-1:0];
                default: ;
            endcase
        end
    end

    // zero acts as 1; oversize byte width, row and plane counts saturate at the store dimensions
    always_comb begin
        cfg.byte_width = (r_bw == '0) ? 7'd1 :
                         (r_bw > 7'(bxd_pkg::MAX_BYTE_WIDTH)) ? 7'(bxd_pkg::MAX_BYTE_WIDTH)
                                                               : r_bw;
        cfg.tile_height = (r_th == '0) ? 9'd1 : r_th;
        cfg.image_rows  = (r_nr == '0) ? 9'd1 :
                          (r_nr > 9'(bxd_pkg::MAX_ROWS)) ? 9'(bxd_pkg::MAX_ROWS) : r_nr;
        cfg.plane_count = (r_np == '0) ? 4'd1 :
                          (r_np > 4'(bxd_pkg::MAX_PLANES)) ? 4'(bxd_pkg::MAX_PLANES) : r_np;
    end

    // ---------------- handshake ----------------
    logic r_s1_valid;
    logic r_o_valid;
    logic s1_adv;
    logic in_acc;

    assign s1_adv      = r_s1_valid && (!r_o_valid || o_out.ready);
    assign i_in.ready  = !r_s1_valid || s1_adv;
    assign in_acc      = i_in.valid && i_in.ready;

    // ---------------- position and reference ----------------
    bxd_pkg::t_pos              pos;
    bxd_pkg::t_ref              ref_q;
    logic [bxd_pkg::ADDR_W-1:0] own_addr;

    bxd_pos u_pos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_adv   (in_acc),
        .i_mode  (i_in.filter_mode),
        .o_pos   (pos),
        .o_addr  (own_addr),
        .o_ref   (ref_q)
    );

    // ---------------- compute stage ----------------
    logic [bxd_pkg::BYTE_W-1:0] r_s1_byte;
    logic [bxd_pkg::MODE_W-1:0] r_s1_mode;
    bxd_pkg::t_pos              r_s1_pos;
    logic [bxd_pkg::ADDR_W-1:0] r_s1_addr;
    logic                       r_s1_refzero;
    logic                       r_fwd_hit;
    logic [bxd_pkg::BYTE_W-1:0] r_fwd_data;
    logic                       r_carry;
    logic [bxd_pkg::BYTE_W-1:0] rdata;
    logic [bxd_pkg::BYTE_W-1:0] ref_byte;
    logic [bxd_pkg::BYTE_W-1:0] inv;
    logic [bxd_pkg::BYTE_W-1:0] res;
    logic [bxd_pkg::BYTE_W-1:0] pre_in;

    bxd_store u_store (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1_addr),
        .i_wdata (res),
        .i_re    (in_acc),
        .i_raddr (ref_q.addr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_carry    <= 1'b0;
            r_fwd_hit  <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_carry <= res[0];
            end
            // reference read races the older item's write-back
            if (in_acc) begin
                r_fwd_hit <= s1_adv && (r_s1_addr == ref_q.addr);
            end else if (s1_adv) begin
                r_fwd_hit <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_byte    <= i_in.filtered_byte;
            r_s1_mode    <= i_in.filter_mode;
            r_s1_pos     <= pos;
            r_s1_addr    <= own_addr;
            r_s1_refzero <= ref_q.zero;
            r_fwd_data   <= res;
        end
    end

    assign inv      = {bxd_pkg::BYTE_W{r_s1_mode[bxd_pkg::MODE_INV_BIT]}};
    assign ref_byte = r_s1_refzero ? '0 : (r_fwd_hit ? r_fwd_data : rdata);
    // row carry enters at the MSB, never on column 0
    assign pre_in   = r_s1_byte ^ inv ^
                      {(r_s1_pos.col != '0) && r_carry, {(bxd_pkg::BYTE_W-1){1'b0}}};

    always_comb begin
        case (r_s1_mode[2:0])
            bxd_pkg::SEL_NONE:   res = r_s1_byte ^ inv;
            bxd_pkg::SEL_PREFIX: res = bxd_pkg::prefix_xor(pre_in);
            default:             res = r_s1_byte ^ ref_byte ^ inv;
        endcase
    end

    // ---------------- output register ----------------
    logic [bxd_pkg::BYTE_W-1:0] r_o_byte;
    bxd_pkg::t_pos              r_o_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s1_adv) begin
            r_o_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_o_byte <= res;
            r_o_pos  <= r_s1_pos;
        end
    end

    assign o_out.valid         = r_o_valid;
    assign o_out.pixel_byte    = r_o_byte;
    assign o_out.plane_index   = r_o_pos.plane;
    assign o_out.row_index     = r_o_pos.row;
    assign o_out.column_index  = r_o_pos.col;
    assign o_out.last_of_row   = r_o_pos.last_row;
    assign o_out.last_of_image = r_o_pos.last_img;

    // ---------------- assertions ----------------
    `BXD_ASSERT_NOW(a_acc_room, i_clk, i_rst_n, in_acc, !r_s1_valid || s1_adv, "accept into full stage")
    `BXD_ASSERT_NEXT(a_s1_hold, i_clk, i_rst_n, r_s1_valid && !s1_adv, r_s1_valid && $stable(r_s1_addr), "compute stage lost item")
    `BXD_ASSERT_NOW(a_fwd_live, i_clk, i_rst_n, r_fwd_hit, r_s1_valid, "forward flag without item")
    `BXD_ASSERT_NOW(a_last_img, i_clk, i_rst_n, r_o_valid && r_o_pos.last_img, r_o_pos.last_row, "image end off row end")
endmodule
